@@ sv/natural_log_series_unit_defines.svh @@
// Assertion macros shared by the checker
`ifndef NATURAL_LOG_SERIES_UNIT_DEFINES_SVH
`define NATURAL_LOG_SERIES_UNIT_DEFINES_SVH

// Implication checked on every rising edge, masked while reset is high
`define NLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define NLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/nls_pkg.sv @@
//------------------------------------------------------------------------------
// nls_pkg
// Types and constants of the natural log series unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nls_pkg;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   localparam logic [7:0] CSR_STOP_MODE  = 8'd0;
   localparam logic [7:0] CSR_TERM_COUNT = 8'd1;

   typedef struct packed {
      logic [31:0] x_value;
      logic [31:0] tolerance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] log_value;
      logic [4:0]         terms_used;
      logic [32:0]        remainder;
      logic               input_error;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic               zero;
      logic signed [5:0]  m;
      logic [31:0]        z;
      logic [33:0]        tol4;
      logic               stop_mode;
      logic [6:0]         limit;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_A, ST_CHECK, ST_MUL1, ST_MUL2, ST_DIV_T, ST_ACC,
      ST_FIN1, ST_FIN2, ST_OUT
   } state_type;
endpackage
`default_nettype wire

@@ sv/nls_front.sv @@
//------------------------------------------------------------------------------
// nls_front
// Accepts items, finds the leading one and normalises x, holds the job queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nls_front #(
   parameter int MAX_TERMS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  nls_pkg::req_type    req_data,
   input  wire                 stop_mode,
   input  wire  [4:0]          term_count,
   output logic                job_valid,
   input  wire                 job_take,
   output nls_pkg::job_type    job
);
   import nls_pkg::*;

   localparam int LW = 7;

   job_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   job_type    cls;
   logic [4:0] p;
   logic       acc;

   always_comb begin
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (req_data.x_value[i]) p = 5'(i);
      end
      cls.zero      = (req_data.x_value == 32'd0);
      cls.m         = 6'(signed'({1'b0, p})) - 6'sd15;
      cls.z         = req_data.x_value << (5'd31 - p);
      cls.tol4      = {req_data.tolerance, 2'b00};
      cls.stop_mode = stop_mode;
      if (stop_mode) cls.limit = LW'(MAX_TERMS);
      else if (32'(term_count) < MAX_TERMS) cls.limit = LW'(term_count);
      else cls.limit = LW'(MAX_TERMS);
   end

   assign full      = (cnt_ff == 2'd2);
   assign acc       = push && !full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ acc;
      rp_in  = rp_ff ^ (job_take && job_valid);
      cnt_in = cnt_ff + 2'(acc) - 2'(job_take && job_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (acc) q_ff[wp_ff] <= cls;
   end
endmodule
`default_nettype wire

@@ sv/nls_divider.sv @@
//------------------------------------------------------------------------------
// nls_divider
// Restoring divider, one quotient bit a cycle, 64-bit dividend, 34-bit divisor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nls_divider (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   input  wire  [33:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [34:0] r_ff, r_in;
   logic [33:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [34:0] sh;

   assign quotient = q_ff;
   assign done     = busy_ff && (n_ff == 7'd0);

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff; busy_in = busy_ff;
      sh = {r_ff[33:0], q_ff[63]};
      if (start) begin
         q_in = dividend; r_in = 35'd0; d_in = divisor; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff && n_ff != 7'd0) begin
         n_in = n_ff - 7'd1;
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff    <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         n_ff    <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule
`default_nettype wire

@@ sv/nls_back.sv @@
//------------------------------------------------------------------------------
// nls_back
// Series sequencer: forms a, the powers and terms on a shared multiplier and
// divider, accumulates the sum and holds the result item.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nls_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 job_valid,
   output logic                job_take,
   input  nls_pkg::job_type    job,
   output logic                rsp_valid,
   input  wire                 rsp_take,
   output nls_pkg::rsp_type    rsp
);
   import nls_pkg::*;

   state_type   state_ff, state_in;
   job_type     job_ff;
   logic [31:0] a_ff, a_in, pw_ff, pw_in;
   logic [32:0] term_ff, term_in;
   logic [36:0] sum_ff, sum_in;
   logic [6:0]  k_ff, k_in;
   logic [63:0] v_ff, v_in;
   rsp_type     rsp_ff, rsp_in;
   logic        out_ff, out_in;
   logic        dv_start, dv_done;
   logic [63:0] dv_dend, dv_q;
   logic [33:0] dv_sor;
   logic [63:0] prod;
   logic        go_on;
   logic [63:0] lnm, u;

   nls_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_dend),
      .divisor(dv_sor), .done(dv_done), .quotient(dv_q)
   );

   assign prod      = pw_ff * a_ff;
   assign rsp_valid = out_ff;
   assign rsp       = rsp_ff;
   assign go_on     = (k_ff < job_ff.limit) &&
                      !(job_ff.stop_mode && ({1'b0, term_ff} < job_ff.tol4));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (job_valid && !out_ff) state_in = job.zero ? ST_OUT : ST_DIV_A;
         ST_DIV_A: if (dv_done) state_in = ST_CHECK;
         ST_CHECK: state_in = go_on ? ((k_ff == 7'd0) ? ST_DIV_T : ST_MUL1) : ST_FIN1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DIV_T;
         ST_DIV_T: if (dv_done) state_in = ST_ACC;
         ST_ACC:   state_in = ST_CHECK;
         ST_FIN1:  state_in = ST_FIN2;
         ST_FIN2:  state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      a_in = a_ff; pw_in = pw_ff; term_in = term_ff; sum_in = sum_ff; k_in = k_ff;
      v_in = v_ff; rsp_in = rsp_ff; out_in = out_ff;
      job_take = 1'b0; dv_start = 1'b0;
      dv_dend = {32'(ONE_Q32 - {1'b0, job_ff.z}), 32'd0};
      dv_sor  = {1'b0, ONE_Q32 + {1'b0, job_ff.z}};
      lnm = 64'(signed'(job_ff.m)) * {32'd0, LN2_Q32};
      u   = v_ff + 64'h100_0000_0000;
      if (out_ff && rsp_take) out_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid && !out_ff) begin
               job_take = 1'b1;
               dv_start = !job.zero;
               dv_dend  = {32'(ONE_Q32 - {1'b0, job.z}), 32'd0};
               dv_sor   = {1'b0, ONE_Q32 + {1'b0, job.z}};
               term_in  = ONE_Q32;
               sum_in   = 37'd0;
               k_in     = 7'd0;
               rsp_in.log_value   = 32'sd0;
               rsp_in.terms_used  = 5'd0;
               rsp_in.remainder   = ONE_Q32;
               rsp_in.input_error = job.zero;
            end
         end
         ST_DIV_A: if (dv_done) begin
            a_in  = dv_q[31:0];
            pw_in = dv_q[31:0];
         end
         ST_MUL1:  pw_in = prod[63:32];
         ST_MUL2:  pw_in = prod[63:32];
         ST_CHECK: begin
            if (go_on) begin
               k_in = k_ff + 7'd1;
               if (k_ff == 7'd0) begin
                  dv_start = 1'b1;
                  dv_dend  = {32'd0, pw_ff};
                  dv_sor   = 34'd1;
               end
            end
         end
         ST_DIV_T: begin
            dv_dend = {32'd0, pw_ff};
            dv_sor  = {26'd0, k_ff, 1'b0} - 34'd1;
            if (dv_done) term_in = {1'b0, dv_q[31:0]};
         end
         ST_ACC:   sum_in = sum_ff + {4'd0, term_ff};
         ST_FIN1:  v_in = lnm - {26'd0, sum_ff, 1'b0};
         ST_FIN2: begin
            rsp_in.log_value  = 32'((u + 64'd128) >> 8);
            rsp_in.terms_used = k_ff[4:0];
            rsp_in.remainder  = term_ff;
         end
         ST_OUT:   out_in = 1'b1;
         default:  ;
      endcase
      // kick the term division on entry from the second multiply step
      if (state_ff == ST_MUL2) begin
         dv_start = 1'b1;
         dv_dend  = {32'd0, prod[63:32]};
         dv_sor   = {26'd0, k_ff, 1'b0} - 34'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
      if (job_take) job_ff <= job;
      a_ff <= a_in; pw_ff <= pw_in; term_ff <= term_in; sum_ff <= sum_in;
      k_ff <= k_in; v_ff <= v_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

@@ sv/natural_log_series_unit.sv @@
//------------------------------------------------------------------------------
// natural_log_series_unit
// ln(x) by power-of-two reduction and the atanh series.
//------------------------------------------------------------------------------
// Input queue: push an item {x_value, tolerance} while full is low.
// Result queue: while empty is low the oldest result sits on rsp_data;
// pop takes it.
// CSR port: csr_index 0 = stop_mode, 1 = term_count, written on csr_valid and
// csr_ready; other indexes are dropped. Write only while the unit is idle.
// Sequencing: the front queues up to two items. The back runs a restoring
// divide for a, then per term two multiplies and a divide; the first term skips
// the multiplies. At most MAX_TERMS terms are summed. A zero x skips the series
// and gives its error result. The next item starts once the result is popped.
// One result register: while it waits for pop the back holds, the front keeps
// filling until full. Reset clears the queues and sets stop_mode 1,
// term_count 8.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module natural_log_series_unit #(
   parameter int MAX_TERMS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  nls_pkg::req_type  req_data,
   output logic              empty,
   input  wire               pop,
   output nls_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [7:0]        csr_index,
   input  wire  [31:0]       csr_data
);
   import nls_pkg::*;

   logic       stop_ff;
   logic [4:0] count_ff;
   logic       jv, jt, rv;
   job_type    job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff  <= 1'b1;
         count_ff <= 5'd8;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STOP_MODE:  stop_ff  <= csr_data[0];
            CSR_TERM_COUNT: count_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   nls_front #(.MAX_TERMS(MAX_TERMS)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .stop_mode(stop_ff), .term_count(count_ff), .job_valid(jv), .job_take(jt),
      .job(job)
   );

   nls_back u_back (
      .clock(clock), .reset(reset), .job_valid(jv), .job_take(jt), .job(job),
      .rsp_valid(rv), .rsp_take(pop), .rsp(rsp_data)
   );

   assign empty = !rv;
endmodule
`default_nettype wire

@@ sv/nls_checker.sv @@
//------------------------------------------------------------------------------
// nls_checker
// Port-level checks of the natural log series unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "natural_log_series_unit_defines.svh"
module nls_checker (
   input wire              clock,
   input wire              reset,
   input wire              empty,
   input wire              pop,
   input nls_pkg::rsp_type rsp_data
);
   import nls_pkg::*;

   `NLS_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, empty, "result after reset")
   `NLS_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_data), "result dropped")
   `NLS_ASSERT_IMP(a_err_fields, clock, reset, !empty && rsp_data.input_error,
      rsp_data.terms_used == 5'd0 && rsp_data.remainder == ONE_Q32, "bad error item")
   `NLS_ASSERT_IMP(a_no_term_one, clock, reset, !empty && rsp_data.terms_used == 5'd0,
      rsp_data.remainder == ONE_Q32, "remainder without term")
endmodule

bind natural_log_series_unit nls_checker u_nls_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop), .rsp_data(rsp_data)
);
`default_nettype wire
